>>> rtl/core/mfps_pkg.sv
package mfps_pkg;

    localparam int CELL_W = 16;
    localparam int SUM_W  = 32;
    localparam int BEST_W = 31;
    localparam int COL_W  = 7;
    localparam int CFG_W  = 7;
    localparam int MIN_SIZE = 3;
    localparam int MAX_SIZE = 64;

    typedef logic signed [CELL_W-1:0] cell_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef struct packed {
        logic first_row;
        logic use_left;
        logic use_right;
    } mfps_ctl_t;

    localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

>>> rtl/core/mfps_line.sv
module mfps_line
    import mfps_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW = 6
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  sum_t          wr_data,
    input  logic [AW-1:0] rd_addr,
    output sum_t          rd_data
);

    sum_t mem [DEPTH];
    sum_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/mfps_cell.sv
module mfps_cell
    import mfps_pkg::*;
(
    input  cell_t     elem,
    input  sum_t      above_left,
    input  sum_t      above,
    input  sum_t      above_right,
    input  mfps_ctl_t ctl,
    output sum_t      sum
);

    sum_t                 best_above;
    logic signed [SUM_W:0] wide_sum;

    always_comb
    begin
        best_above = above;
        if (ctl.use_left && (above_left > best_above))
        begin
            best_above = above_left;
        end
        if (ctl.use_right && (above_right > best_above))
        begin
            best_above = above_right;
        end
        wide_sum = (SUM_W+1)'(elem) + (SUM_W+1)'(best_above);
        if (ctl.first_row)
        begin
            sum = SUM_W'(elem);
        end
        else if (wide_sum[SUM_W] != wide_sum[SUM_W-1])
        begin
            sum = wide_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum = wide_sum[SUM_W-1:0];
        end
    end

endmodule

>>> rtl/core/max_falling_path_sum.sv
// Maximum falling path sum over an n-by-n signed grid streamed in row-major
// order, n set by grid_size (clamped to 3..MAX_SIZE; any write restarts the
// grid). One element is taken per clock while cfg_valid is low; the result
// (best bottom-row sum and its 1-based column, both 0 if no sum is
// positive) is registered and shows in the cycle after the last element is
// taken. The rate is set by the line store: one write and one registered
// read per cycle, with the upper-right sum prefetched. Elements keep flowing
// while a result waits; only the next grid's last element is held back.
module max_falling_path_sum
    import mfps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    grid_size,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  cell_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [BEST_W-1:0]   best_sum,
    output logic [COL_W-1:0]    best_column
);

    localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int NW = $clog2(MAX_SIZE + 1);

    logic [NW-1:0]     size_reg, size_next;
    logic [AW-1:0]     col_reg, col_next;
    logic [AW-1:0]     row_reg, row_next;
    sum_t              left_reg, left_next;
    sum_t              cur_reg, cur_next;
    sum_t              first_reg, first_next;
    logic [BEST_W-1:0] best_reg, best_next;
    logic [COL_W-1:0]  best_col_reg, best_col_next;
    logic              out_valid_reg, out_valid_next;
    logic [BEST_W-1:0] out_sum_reg, out_sum_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;

    logic [NW-1:0]     size_m1;
    logic              last_col, last_row, last_pos;
    logic              in_acc, cfg_acc;
    logic [AW-1:0]     rd_addr;
    sum_t              right_sum;
    sum_t              sum;
    mfps_ctl_t         ctl;
    logic [31:0]       col_plus;
    logic [BEST_W-1:0] upd_best;
    logic [COL_W-1:0]  upd_col;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign size_m1   = size_reg - NW'(1);
    assign last_col  = (col_reg == size_m1[AW-1:0]);
    assign last_row  = (row_reg == size_m1[AW-1:0]);
    assign last_pos  = last_col && last_row;
    assign in_ready  = !cfg_valid && (!out_valid_reg || out_ready || !last_pos);
    assign in_acc    = in_valid && in_ready;

    assign ctl.first_row = (row_reg == '0);
    assign ctl.use_left  = (col_reg != '0);
    assign ctl.use_right = !last_col;

    mfps_cell u_cell (
        .elem        (cell_value),
        .above_left  (left_reg),
        .above       (cur_reg),
        .above_right (right_sum),
        .ctl         (ctl),
        .sum         (sum)
    );

    assign rd_addr = col_next + AW'(1);

    mfps_line #(
        .DEPTH (MAX_SIZE),
        .AW    (AW)
    ) u_line (
        .clk     (clk),
        .wr_en   (in_acc && !cfg_acc),
        .wr_addr (col_reg),
        .wr_data (sum),
        .rd_addr (rd_addr),
        .rd_data (right_sum)
    );

    assign col_plus = 32'(col_reg) + 32'd1;

    always_comb
    begin
        upd_best = best_reg;
        upd_col  = best_col_reg;
        if (last_row && (sum > 0) && (sum[BEST_W-1:0] > best_reg))
        begin
            upd_best = sum[BEST_W-1:0];
            upd_col  = col_plus[COL_W-1:0];
        end
    end

    always_comb
    begin
        size_next      = size_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        left_next      = left_reg;
        cur_next       = cur_reg;
        first_next     = first_reg;
        best_next      = best_reg;
        best_col_next  = best_col_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_sum_next   = out_sum_reg;
        out_col_next   = out_col_reg;
        if (cfg_acc)
        begin
            if (grid_size < CFG_W'(MIN_SIZE))
            begin
                size_next = NW'(MIN_SIZE);
            end
            else if (32'(grid_size) > 32'(MAX_SIZE))
            begin
                size_next = NW'(MAX_SIZE);
            end
            else
            begin
                size_next = NW'(grid_size);
            end
            col_next      = '0;
            row_next      = '0;
            left_next     = '0;
            best_next     = '0;
            best_col_next = '0;
        end
        else if (in_acc)
        begin
            best_next     = upd_best;
            best_col_next = upd_col;
            if (col_reg == '0)
            begin
                first_next = sum;
            end
            if (last_col)
            begin
                col_next  = '0;
                left_next = '0;
                cur_next  = first_reg;
                if (last_row)
                begin
                    row_next       = '0;
                    best_next      = '0;
                    best_col_next  = '0;
                    out_valid_next = 1'b1;
                    out_sum_next   = upd_best;
                    out_col_next   = upd_col;
                end
                else
                begin
                    row_next = row_reg + AW'(1);
                end
            end
            else
            begin
                col_next  = col_reg + AW'(1);
                left_next = cur_reg;
                cur_next  = right_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= NW'(MIN_SIZE);
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            best_reg      <= '0;
            best_col_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            size_reg      <= size_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            left_reg      <= left_next;
            best_reg      <= best_next;
            best_col_reg  <= best_col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        first_reg   <= first_next;
        out_sum_reg <= out_sum_next;
        out_col_reg <= out_col_next;
    end

    assign out_valid   = out_valid_reg;
    assign best_sum    = out_sum_reg;
    assign best_column = out_col_reg;

    // last element of a grid always produces a result
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !cfg_acc && last_pos) |=> out_valid_reg)
        else $error("result missing after last element");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_acc && last_pos && out_valid_reg && !out_ready))
        else $error("last element taken while result stalled");

    // zero column goes with zero sum
    a_col_sum_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_col_reg == '0) == (out_sum_reg == '0)))
        else $error("best column and best sum disagree");

endmodule
